### rtl/core/pca_pkg.sv
// Shared constants, types and code points for the pressure calibration block.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package pca_pkg;

  // Field widths.
  localparam int SAMPLE_W = 10;
  localparam int OFFSET_W = 10;
  localparam int SENS_W   = 15;
  localparam int PRESS_W  = 16;

  // Moving-average window and the ring that holds it.
  localparam int WINDOW  = 10;
  localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int TOTAL_W = PRESS_W + $clog2(WINDOW);
  localparam int TMAG_W  = TOTAL_W - 1;

  // Calibration product |sample - offset| * sensitivity, unsigned.
  localparam int PROD_W = SAMPLE_W + SENS_W;

  // Division by 1000 as a multiplication by a rounded-up reciprocal. With the
  // shift chosen this way the floor of the scaled product is exact for every
  // product magnitude that fits PROD_W bits.
  localparam int CAL_DIV     = 1000;
  localparam int CAL_SHIFT   = PROD_W + $clog2(CAL_DIV);
  localparam int CAL_RECIP_W = CAL_SHIFT - $clog2(CAL_DIV) + 1;
  localparam longint unsigned CAL_RECIP_L =
    ((64'd1 << CAL_SHIFT) + CAL_DIV - 1) / CAL_DIV;
  localparam logic [CAL_RECIP_W-1:0] CAL_RECIP = CAL_RECIP_W'(CAL_RECIP_L);
  localparam int CAL_PROD_W = PROD_W + CAL_RECIP_W;

  // Division of the running total by WINDOW, same scheme.
  localparam int MEAN_SHIFT   = TMAG_W + $clog2(WINDOW);
  localparam int MEAN_RECIP_W = MEAN_SHIFT - $clog2(WINDOW) + 1;
  localparam longint unsigned MEAN_RECIP_L =
    ((64'd1 << MEAN_SHIFT) + WINDOW - 1) / WINDOW;
  localparam logic [MEAN_RECIP_W-1:0] MEAN_RECIP = MEAN_RECIP_W'(MEAN_RECIP_L);
  localparam int MEAN_PROD_W = TMAG_W + MEAN_RECIP_W;

  // Saturation limits on a quotient magnitude.
  localparam logic [PRESS_W-1:0] MAG_NEG_LIMIT = PRESS_W'(1) << (PRESS_W - 1);
  localparam logic [PRESS_W-1:0] MAG_POS_LIMIT = MAG_NEG_LIMIT - PRESS_W'(1);
  localparam logic signed [PRESS_W-1:0] PRESS_MAX = MAG_POS_LIMIT;
  localparam logic signed [PRESS_W-1:0] PRESS_MIN = MAG_NEG_LIMIT;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = SENS_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZERO_OFFSET = 2'd0,
    CFG_SENSITIVITY = 2'd1
  } cfg_reg_e;

  localparam logic [OFFSET_W-1:0] OFFSET_RESET = '0;
  localparam logic [SENS_W-1:0]   SENS_RESET   = SENS_W'(8800);

  // Register stages from input acceptance to the result register.
  localparam int PIPE_DEPTH = 5;

  // Calibrated quotient in sign and magnitude, before saturation.
  typedef struct packed {
    logic               neg;
    logic [PRESS_W-1:0] mag;
  } calib_word_t;

endpackage

`default_nettype wire

### rtl/core/pca_in_if.sv
// Input channel of the pressure block: one converter sample per word.
// Depends on pca_pkg for the field width.
`default_nettype none

interface pca_in_if;

  logic                          valid;
  logic                          ready;
  logic [pca_pkg::SAMPLE_W-1:0]  adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);

endinterface

`default_nettype wire

### rtl/core/pca_out_if.sv
// Output channel of the pressure block: instant and filtered pressure per word.
// Depends on pca_pkg for the field widths.
`default_nettype none

interface pca_out_if;

  logic                                valid;
  logic                                ready;
  logic signed [pca_pkg::PRESS_W-1:0]  pressure_now;
  logic signed [pca_pkg::PRESS_W-1:0]  pressure_filtered;

  modport source (output valid, output pressure_now, output pressure_filtered, input ready);
  modport sink   (input valid, input pressure_now, input pressure_filtered, output ready);

endinterface

`default_nettype wire

### rtl/core/pca_calib.sv
// Calibration front end: input register, offset and gain multiply, divide by 1000.
// Depends on pca_pkg and pca_in_if; hands a sign and magnitude word downstream.
`default_nettype none

module pca_calib (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [pca_pkg::OFFSET_W-1:0]  zero_offset_i,
  input  wire logic [pca_pkg::SENS_W-1:0]    sensitivity_i,
  pca_in_if.sink                             in_ch,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output pca_pkg::calib_word_t               out_word_o
);

  // Stage valid flags and payloads.
  logic                               s1_v_q, s2_v_q, s3_v_q;
  logic [pca_pkg::SAMPLE_W-1:0]       s1_sample_q;
  logic                               s2_neg_q;
  logic [pca_pkg::PROD_W-1:0]         s2_prod_q;
  pca_pkg::calib_word_t               s3_word_q;

  logic                               en1, en2, en3;
  logic                               diff_neg;
  logic [pca_pkg::SAMPLE_W-1:0]       diff_mag;
  logic [pca_pkg::PROD_W-1:0]         prod_d;
  logic [pca_pkg::CAL_PROD_W-1:0]     scaled;

  // A stage loads when it is empty or its word moves on in the same cycle.
  assign en3 = !s3_v_q || out_ready_i;
  assign en2 = !s2_v_q || en3;
  assign en1 = !s1_v_q || en2;
  assign in_ch.ready = en1;

  // Offset removal in sign and magnitude, then the gain multiply.
  assign diff_neg = s1_sample_q < zero_offset_i;
  assign diff_mag = diff_neg ? (zero_offset_i - s1_sample_q) : (s1_sample_q - zero_offset_i);
  assign prod_d   = pca_pkg::PROD_W'(diff_mag) * pca_pkg::PROD_W'(sensitivity_i);

  // Divide the magnitude by 1000 with the reciprocal; truncation toward zero.
  assign scaled = pca_pkg::CAL_PROD_W'(s2_prod_q) * pca_pkg::CAL_PROD_W'(pca_pkg::CAL_RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (en1) begin
        s1_v_q <= in_ch.valid;
      end
      if (en2) begin
        s2_v_q <= s1_v_q;
      end
      if (en3) begin
        s3_v_q <= s2_v_q;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en1 && in_ch.valid) begin
      s1_sample_q <= in_ch.adc_sample;
    end
    if (en2 && s1_v_q) begin
      s2_neg_q  <= diff_neg;
      s2_prod_q <= prod_d;
    end
    if (en3 && s2_v_q) begin
      s3_word_q.neg <= s2_neg_q;
      s3_word_q.mag <= scaled[pca_pkg::CAL_SHIFT +: pca_pkg::PRESS_W];
    end
  end

  assign out_valid_o = s3_v_q;
  assign out_word_o  = s3_word_q;

endmodule

`default_nettype wire

### rtl/core/pca_average.sv
// Saturation, sample ring with running total, divide by WINDOW and result register.
// Depends on pca_pkg and pca_out_if; fed by pca_calib.
`default_nettype none

module pca_average (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire pca_pkg::calib_word_t in_word_i,
  pca_out_if.source                 out_ch
);

  logic signed [pca_pkg::PRESS_W-1:0]  ring_q [pca_pkg::WINDOW];
  logic [pca_pkg::SLOT_W-1:0]          slot_q;
  logic signed [pca_pkg::TOTAL_W-1:0]  total_q, total_d;

  logic                                s4_v_q;
  logic signed [pca_pkg::PRESS_W-1:0]  s4_now_q;
  logic                                out_v_q;
  logic signed [pca_pkg::PRESS_W-1:0]  now_q, filt_q;

  logic                                en4, en5, take;
  logic signed [pca_pkg::PRESS_W-1:0]  now_d;
  logic                                tot_neg;
  logic [pca_pkg::TMAG_W-1:0]          tot_mag;
  logic [pca_pkg::MEAN_PROD_W-1:0]     mean_prod;
  logic [pca_pkg::PRESS_W-1:0]         mean_mag;
  logic signed [pca_pkg::PRESS_W-1:0]  mean_d;

  assign en5        = !out_v_q || out_ch.ready;
  assign en4        = !s4_v_q || en5;
  assign in_ready_o = en4;
  assign take       = en4 && in_valid_i;

  // Apply the sign and clamp to the 16-bit range.
  always_comb begin
    if (in_word_i.neg) begin
      now_d = (in_word_i.mag > pca_pkg::MAG_NEG_LIMIT) ? pca_pkg::PRESS_MIN
                                                       : $signed(~in_word_i.mag + 1'b1);
    end else begin
      now_d = (in_word_i.mag > pca_pkg::MAG_POS_LIMIT) ? pca_pkg::PRESS_MAX
                                                       : $signed(in_word_i.mag);
    end
  end

  // The oldest value leaves the total as the new one enters.
  assign total_d = total_q - pca_pkg::TOTAL_W'(ring_q[slot_q]) + pca_pkg::TOTAL_W'(now_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < pca_pkg::WINDOW; i++) begin
        ring_q[i] <= '0;
      end
      slot_q  <= '0;
      total_q <= '0;
      s4_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (take) begin
        ring_q[slot_q] <= now_d;
        total_q        <= total_d;
        slot_q         <= (slot_q == pca_pkg::SLOT_W'(pca_pkg::WINDOW - 1))
                          ? '0 : slot_q + 1'b1;
      end
      if (en4) begin
        s4_v_q <= in_valid_i;
      end
      if (en5) begin
        out_v_q <= s4_v_q;
      end
    end
  end

  // Mean of the ring. The total only changes when a word enters this stage,
  // so total_q always belongs to the word held in s4.
  assign tot_neg   = total_q[pca_pkg::TOTAL_W-1];
  assign tot_mag   = tot_neg ? pca_pkg::TMAG_W'(-total_q) : pca_pkg::TMAG_W'(total_q);
  assign mean_prod = pca_pkg::MEAN_PROD_W'(tot_mag) *
                     pca_pkg::MEAN_PROD_W'(pca_pkg::MEAN_RECIP);
  assign mean_mag  = mean_prod[pca_pkg::MEAN_SHIFT +: pca_pkg::PRESS_W];
  assign mean_d    = tot_neg ? $signed(~mean_mag + 1'b1) : $signed(mean_mag);

  always_ff @(posedge clk_i) begin
    if (take) begin
      s4_now_q <= now_d;
    end
    if (en5 && s4_v_q) begin
      now_q  <= s4_now_q;
      filt_q <= mean_d;
    end
  end

  assign out_ch.valid             = out_v_q;
  assign out_ch.pressure_now      = now_q;
  assign out_ch.pressure_filtered = filt_q;

endmodule

`default_nettype wire

### rtl/core/pressure_calibrate_and_average.sv
// Pressure calibration with a moving average, top level.
// Depends on pca_pkg, pca_in_if, pca_out_if, pca_calib and pca_average.
//
// Each sample word gives one result word: pressure_now = (adc_sample -
// zero_offset) * sensitivity / 1000 in tenths of a bar, and pressure_filtered
// = the sum of the last WINDOW instant values / WINDOW, both truncated toward
// zero. The ring of past values is zero after reset, so the filtered value
// ramps up over the first WINDOW words. The block sustains one word per clock
// cycle while the output is ready. A word passes through five register stages
// (input, gain multiply, reciprocal divide, ring update, mean and result), and
// a running total is kept beside the ring for the ring update. Stalls on the
// output fill empty stages first, so input words keep being taken until all
// five are full. The user must write the configuration registers only while
// no word is in flight; the block itself does not enforce this.
`default_nettype none

module pressure_calibrate_and_average (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [pca_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [pca_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  pca_in_if.sink                               in_ch,
  pca_out_if.source                            out_ch
);

  logic [pca_pkg::OFFSET_W-1:0]  zero_offset_q;
  logic [pca_pkg::SENS_W-1:0]    sensitivity_q;

  logic                          mid_valid;
  logic                          mid_ready;
  pca_pkg::calib_word_t          mid_word;

  // Configuration registers; indexes beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_offset_q <= pca_pkg::OFFSET_RESET;
      sensitivity_q <= pca_pkg::SENS_RESET;
    end else if (cfg_we_i) begin
      case (pca_pkg::cfg_reg_e'(cfg_idx_i))
        pca_pkg::CFG_ZERO_OFFSET: zero_offset_q <= cfg_data_i[pca_pkg::OFFSET_W-1:0];
        pca_pkg::CFG_SENSITIVITY: sensitivity_q <= cfg_data_i[pca_pkg::SENS_W-1:0];
        default: ;
      endcase
    end
  end

  pca_calib u_calib (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .zero_offset_i (zero_offset_q),
    .sensitivity_i (sensitivity_q),
    .in_ch         (in_ch),
    .out_valid_o   (mid_valid),
    .out_ready_i   (mid_ready),
    .out_word_o    (mid_word)
  );

  pca_average u_average (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (mid_valid),
    .in_ready_o (mid_ready),
    .in_word_i  (mid_word),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

### rtl/core/pca_checker.sv
// Port-level checks for the pressure calibration block, bound to the top level.
// Depends on pca_pkg for the pipeline depth and field widths.
`default_nettype none

module pca_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               in_valid_i,
  input wire logic                               in_ready_i,
  input wire logic                               out_valid_i,
  input wire logic                               out_ready_i,
  input wire logic signed [pca_pkg::PRESS_W-1:0] now_i,
  input wire logic signed [pca_pkg::PRESS_W-1:0] filt_i
);

  localparam int CNT_W = $clog2(pca_pkg::PIPE_DEPTH + 1);

  logic [CNT_W-1:0] cnt_q;
  logic             in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // Words accepted and not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + CNT_W'(in_acc) - CNT_W'(out_acc);
    end
  end

  // A result is only shown for a word that was taken in.
  a_no_orphan_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cnt_q != '0)
    else $error("result word without an accepted sample");

  // No more words in flight than there are stages.
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(pca_pkg::PIPE_DEPTH))
    else $error("more words in flight than pipeline stages");

  // Any free stage lets a new sample in.
  a_ready_when_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < CNT_W'(pca_pkg::PIPE_DEPTH) |-> in_ready_i)
    else $error("input stalled while a stage is free");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(now_i) && $stable(filt_i))
    else $error("stalled result word changed");

endmodule

bind pressure_calibrate_and_average pca_checker u_pca_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch.valid),
  .in_ready_i  (in_ch.ready),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .now_i       (out_ch.pressure_now),
  .filt_i      (out_ch.pressure_filtered)
);

`default_nettype wire

### verif/tb_pressure_calibrate_and_average.sv
// Self-checking testbench for pressure_calibrate_and_average: a directed table of
// sample words, then random phases under new calibration settings.
// Depends on pca_pkg, pca_in_if, pca_out_if and the block's RTL.
`default_nettype none

module tb_pressure_calibrate_and_average;

  import pca_pkg::*;

  // Register indexes outside the block's list; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 2'd3;

  localparam int RANDOM_PHASES   = 9;
  localparam int WORDS_PER_PHASE = 100;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int PLAN_ROWS       = 18;

  typedef struct packed {
    logic signed [PRESS_W-1:0] now_tenths;
    logic signed [PRESS_W-1:0] mean_tenths;
  } reading_t;

  typedef enum logic {ROW_REGS, ROW_WORD} row_kind_e;

  typedef struct {
    row_kind_e            kind;
    logic [OFFSET_W-1:0]  offs;
    logic [SENS_W-1:0]    sens;
    bit                   stray;
    logic [SAMPLE_W-1:0]  sample;
    int unsigned          reps;
    bit                   typed;
    reading_t             lit;
  } stim_row_t;

  // Directed part: reset values, field extremes, gain above the stated range
  // in both directions, truncation toward zero, ignored register indexes, zero
  // gain and runs of six words at either extreme.
  stim_row_t directed_plan [PLAN_ROWS] = '{
    '{ROW_WORD, 10'd0,    15'd0,     1'b0, 10'd0,    1, 1'b1, '{16'sd0,    16'sd0}},
    '{ROW_WORD, 10'd0,    15'd0,     1'b0, 10'd1023, 1, 1'b1, '{16'sd9002, 16'sd900}},
    '{ROW_WORD, 10'd0,    15'd0,     1'b0, 10'd341,  1, 1'b0, '0},
    '{ROW_WORD, 10'd0,    15'd0,     1'b0, 10'd682,  1, 1'b0, '0},
    '{ROW_WORD, 10'd0,    15'd0,     1'b0, 10'd512,  1, 1'b0, '0},
    '{ROW_REGS, 10'd0,    15'd32767, 1'b0, 10'd0,    0, 1'b0, '0},
    '{ROW_WORD, 10'd0,    15'd0,     1'b0, 10'd1023, 2, 1'b0, '0},
    '{ROW_REGS, 10'd1023, 15'd32767, 1'b0, 10'd0,    0, 1'b0, '0},
    '{ROW_WORD, 10'd0,    15'd0,     1'b0, 10'd0,    2, 1'b0, '0},
    '{ROW_REGS, 10'd1023, 15'd8800,  1'b1, 10'd0,    0, 1'b0, '0},
    '{ROW_WORD, 10'd0,    15'd0,     1'b0, 10'd1022, 1, 1'b0, '0},
    '{ROW_WORD, 10'd0,    15'd0,     1'b0, 10'd1023, 1, 1'b0, '0},
    '{ROW_REGS, 10'd0,    15'd0,     1'b0, 10'd0,    0, 1'b0, '0},
    '{ROW_WORD, 10'd0,    15'd0,     1'b0, 10'd1023, 1, 1'b0, '0},
    '{ROW_REGS, 10'd0,    15'd32000, 1'b0, 10'd0,    0, 1'b0, '0},
    '{ROW_WORD, 10'd0,    15'd0,     1'b0, 10'd1023, 6, 1'b0, '0},
    '{ROW_REGS, 10'd1023, 15'd32000, 1'b0, 10'd0,    0, 1'b0, '0},
    '{ROW_WORD, 10'd0,    15'd0,     1'b0, 10'd0,    6, 1'b0, '0}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  pca_in_if  sample_ch ();
  pca_out_if result_ch ();

  pressure_calibrate_and_average u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (sample_ch),
    .out_ch     (result_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mirror of the calibration registers and of the averaging ring.
  logic [OFFSET_W-1:0] cal_offset = OFFSET_RESET;
  logic [SENS_W-1:0]   cal_gain   = SENS_RESET;
  int                  ring_val [WINDOW];
  int                  ring_slot  = 0;
  int                  ring_total = 0;

  reading_t    pressure_due_q [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned burst_left     = 0;

  initial begin
    foreach (ring_val[i]) ring_val[i] = 0;
  end

  // Calibrates one sample, pushes it through the ring and returns both values.
  function automatic reading_t predict_pressure(input logic [SAMPLE_W-1:0] sample);
    int       quo;
    reading_t r;
    quo = ((int'(sample) - int'(cal_offset)) * int'(cal_gain)) / CAL_DIV;
    if (quo > int'(PRESS_MAX)) quo = int'(PRESS_MAX);
    if (quo < int'(PRESS_MIN)) quo = int'(PRESS_MIN);
    ring_total          = ring_total - ring_val[ring_slot] + quo;
    ring_val[ring_slot] = quo;
    ring_slot           = (ring_slot + 1) % WINDOW;
    r.now_tenths  = PRESS_W'(quo);
    r.mean_tenths = PRESS_W'(ring_total / WINDOW);
    return r;
  endfunction

  task automatic wait_idle();
    while (pressure_due_q.size() != 0) @(posedge clk_i);
  endtask

  // Offers one sample word, with bursts and random gaps on the sending side.
  task automatic offer_word(input logic [SAMPLE_W-1:0] sample, input bit typed,
                            input reading_t lit);
    int unsigned gap;
    reading_t    due;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        sample_ch.valid      <= 1'b0;
        sample_ch.adc_sample <= SAMPLE_W'($urandom);
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    sample_ch.valid      <= 1'b1;
    sample_ch.adc_sample <= sample;
    do @(posedge clk_i); while (!(sample_ch.valid && sample_ch.ready));
    due = predict_pressure(sample);
    pressure_due_q.push_back(typed ? lit : due);
  endtask

  // Reprogrammes both registers once the block has drained, optionally with
  // stray writes to the unused indexes.
  task automatic program_regs(input logic [OFFSET_W-1:0] offs,
                              input logic [SENS_W-1:0] sens, input bit stray);
    sample_ch.valid <= 1'b0;
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_ZERO_OFFSET;
    cfg_data_i <= CFG_DATA_W'(offs);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_SENSITIVITY;
    cfg_data_i <= sens;
    @(posedge clk_i);
    if (stray) begin
      cfg_idx_i  <= CFG_IDX_SPARE_LO;
      cfg_data_i <= CFG_DATA_W'($urandom);
      @(posedge clk_i);
      cfg_idx_i  <= CFG_IDX_SPARE_HI;
      cfg_data_i <= CFG_DATA_W'($urandom);
      @(posedge clk_i);
    end
    cfg_we_i   <= 1'b0;
    cal_offset = offs;
    cal_gain   = sens;
  endtask

  // Stimulus: reset, directed table, random phases, then drain.
  initial begin
    logic [OFFSET_W-1:0] offs;
    logic [SENS_W-1:0]   sens;
    logic [SAMPLE_W-1:0] pick;
    logic [SAMPLE_W-1:0] last_pick;
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = CFG_ZERO_OFFSET;
    cfg_data_i           = '0;
    sample_ch.valid      = 1'b0;
    sample_ch.adc_sample = '0;
    result_ch.ready      = 1'b0;
    last_pick            = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_plan[r]) begin
      if (directed_plan[r].kind == ROW_REGS) begin
        program_regs(directed_plan[r].offs, directed_plan[r].sens, directed_plan[r].stray);
      end else begin
        repeat (directed_plan[r].reps)
          offer_word(directed_plan[r].sample, directed_plan[r].typed, directed_plan[r].lit);
      end
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin
          offs = 10'd512;
          sens = SENS_RESET;
        end
        1: begin
          offs = '0;
          sens = 15'd32000;
        end
        2: begin
          offs = '1;
          sens = '1;
        end
        default: begin
          offs = OFFSET_W'($urandom_range(0, 1023));
          sens = ($urandom_range(0, 3) == 0) ? SENS_W'($urandom_range(32001, 32767))
                                             : SENS_W'($urandom_range(0, 32000));
        end
      endcase
      program_regs(offs, sens, $urandom_range(0, 3) == 0);
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        case ($urandom_range(0, 7))
          0:       pick = '0;
          1:       pick = '1;
          2:       pick = cal_offset ^ SAMPLE_W'($urandom_range(0, 3));
          3:       pick = last_pick;
          default: pick = SAMPLE_W'($urandom);
        endcase
        last_pick = pick;
        offer_word(pick, 1'b0, '0);
      end
    end

    sample_ch.valid <= 1'b0;
    wait_idle();
    repeat (4 * PIPE_DEPTH) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Receiver: ready follows one of four patterns, chosen anew at random.
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;

  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(8, 64);
    end
    stall_left--;
    case (stall_mode)
      0:       result_ch.ready <= 1'b1;
      1:       result_ch.ready <= 1'($urandom_range(0, 1));
      2:       result_ch.ready <= ($urandom_range(0, 4) == 0);
      default: result_ch.ready <= (stall_left % 3 != 0);
    endcase
  end

  // Each result word is compared with the oldest expected reading.
  always @(posedge clk_i) begin
    reading_t exp_r;
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      if (pressure_due_q.size() == 0) begin
        $display("%0t unexpected result word: now %0d, filtered %0d", $time,
                 result_ch.pressure_now, result_ch.pressure_filtered);
        mismatch_count++;
      end else begin
        exp_r = pressure_due_q.pop_front();
        if (result_ch.pressure_now !== exp_r.now_tenths) begin
          $display("%0t pressure_now mismatch: expected %0d, actual %0d", $time,
                   exp_r.now_tenths, result_ch.pressure_now);
          mismatch_count++;
        end
        if (result_ch.pressure_filtered !== exp_r.mean_tenths) begin
          $display("%0t pressure_filtered mismatch: expected %0d, actual %0d", $time,
                   exp_r.mean_tenths, result_ch.pressure_filtered);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t timeout, %0d readings still expected", $time, pressure_due_q.size());
      $display("status: fail");
      $finish;
    end
  end

endmodule

`default_nettype wire
